>>> design/lic_pkg.sv
// Shared types and constants of the line integral convolution pixel engine.
// Depends on nothing; lic_div, lic_mul and the top level import it.
package lic_pkg;

  // Store geometry; the datapath widths below are sized for it
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;

  // Fixed datapath widths that follow from the field and register widths
  localparam int POS_W   = 28;  // signed Q.16 position, covers image plus one overshoot
  localparam int SEG_W   = 33;  // exit length, up to the clip length
  localparam int CUR_W   = 34;  // travelled length before the kernel clamp
  localparam int STEP_W  = 23;  // clamped length and step, at most 64 pixels
  localparam int MAG_W   = 16;  // field component magnitude, up to 32768
  localparam int DIVD_W  = 33;  // divider dividend and quotient
  localparam int DIVS_W  = 16;  // divider divisor
  localparam int MUL_A_W = 23;
  localparam int MUL_B_W = 16;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int DIM_W   = 9;   // image size and cell coordinate
  localparam int KLEN_W  = 7;
  localparam int MINC_W  = 15;
  localparam int CNT_W   = 8;   // step count, at most three times 64
  localparam int CFG_W   = 15;  // widest register

  localparam logic [SEG_W-1:0]  CLIP_LEN   = 33'd6553600000;  // 100000 pixels
  localparam logic [STEP_W-1:0] OVERSHOOT  = 23'd26;          // 0.0004 pixel
  localparam logic [KLEN_W-1:0] KERNEL_MAX = 7'd64;
  localparam logic [7:0]        INTENS_MAX = 8'd255;

  typedef enum logic [1:0] {
    CFG_WIDTH,
    CFG_HEIGHT,
    CFG_KERNEL,
    CFG_MINC
  } cfg_idx_e;

  typedef enum logic {
    OP_LOAD,
    OP_QUERY
  } op_e;

  typedef enum logic [4:0] {
    S_CLR,
    S_IDLE,
    S_TINIT,
    S_TCHK,
    S_TVEC,
    S_DXS,
    S_DXW,
    S_DYS,
    S_DYW,
    S_ADV,
    S_MX,
    S_MY,
    S_MW,
    S_SAMP,
    S_WWAIT,
    S_ACC,
    S_ACC2,
    S_TEND,
    S_FIN,
    S_FINW,
    S_OUT
  } state_e;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> design/lic_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module lic_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/lic_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on lic_pkg for widths and the request/response structs.
module lic_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lic_pkg::div_req_t  req_i,
  output lic_pkg::div_rsp_t  rsp_o
);
  import lic_pkg::*;

  localparam int DCNT_W = $clog2(DIVD_W + 1);

  logic [DIVS_W:0]   rem_q, rem_d;
  logic [DIVD_W-1:0] quo_q, quo_d;
  logic [DIVS_W-1:0] dvs_q, dvs_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DIVS_W:0]   trial;
  logic              fits;

  // One shift-compare-subtract step per cycle
  always_comb begin
    trial  = {rem_q[DIVS_W-1:0], quo_q[DIVD_W-1]};
    fits   = trial >= {1'b0, dvs_q};
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      cnt_d  = DCNT_W'(DIVD_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? trial - {1'b0, dvs_q} : trial;
      quo_d = {quo_q[DIVD_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operands
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

>>> design/lic_mul.sv
// Shared unsigned multiplier with a registered product.
// Depends on lic_pkg for operand widths.
module lic_mul (
  input  logic                    clk_i,
  input  logic [lic_pkg::MUL_A_W-1:0] a_i,
  input  logic [lic_pkg::MUL_B_W-1:0] b_i,
  output logic [lic_pkg::PROD_W-1:0]  prod_o
);
  import lic_pkg::*;

  logic [PROD_W-1:0] prod_q;

  // Register the product before any use
  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign prod_o = prod_q;

endmodule

>>> design/line_integral_convolution_pixel.sv
// Top level of the line integral convolution pixel engine: sequencer and datapath.
// Depends on lic_pkg, lic_ram, lic_div and lic_mul.
//
// Usage: the input channel (in_valid_i/in_ready_o) carries requests. A load request
// (op 0) writes a pixel's field vector and noise texel when it is taken and gives no
// result. A query request (op 1) traces the streamline backward, then forward, and
// returns one result (intensity, out_x, out_y) on the output channel
// (out_valid_o/out_ready_i). Configuration is written through cfg_we_i, cfg_addr_i
// and cfg_wdata_i at any time the block is idle.
// Sequence: each trace step uses the shared divider once for the weight and once for
// each exit length whose field component exceeds the minimum; a final division
// normalizes the result when the total weight is non-zero; up to 3*kernel_length
// steps per direction. A query outside the image offers its result in the cycle after
// it is taken. Ready returns in the cycle after the result is taken.
// Reset: a clearing pass writes zero vectors to all MAX_WIDTH*MAX_HEIGHT entries of
// the vector store; no request is taken meanwhile.
// Stall: the result is held in a register until taken; the block takes no new
// request until then.
module line_integral_convolution_pixel #(
  parameter int WEIGHT_TABLE_SIZE = 2048
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_addr_i,
  input  logic [lic_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       op_i,
  input  logic [7:0]                 pixel_x_i,
  input  logic [7:0]                 pixel_y_i,
  input  logic signed [15:0]         vector_x_i,
  input  logic signed [15:0]         vector_y_i,
  input  logic [7:0]                 texel_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [7:0]                 intensity_o,
  output logic [7:0]                 out_x_o,
  output logic [7:0]                 out_y_o
);
  import lic_pkg::*;

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int WGT_W  = $clog2(WEIGHT_TABLE_SIZE);
  localparam int SUM_W  = 8 + WGT_W;
  localparam int TOTS_W = SUM_W + 1;
  localparam int TOTW_W = WGT_W + 1;
  localparam logic [MUL_B_W-1:0] WMAX = MUL_B_W'(WEIGHT_TABLE_SIZE - 1);

  // Store address of a cell
  function automatic logic [ADDR_W-1:0] cell_addr(logic [DIM_W-1:0] cx,
                                                  logic [DIM_W-1:0] cy);
    int a;
    a = int'(cy) * MAX_WIDTH + int'(cx);
    return ADDR_W'(a);
  endfunction

  // Cell of the segment midpoint, saturated into the image
  function automatic logic [DIM_W-1:0] sample_cell(logic signed [POS_W-1:0] a,
                                                   logic signed [POS_W-1:0] b,
                                                   logic [DIM_W-1:0] dim);
    logic signed [POS_W:0] s;
    logic [POS_W-18:0]     c;
    s = {a[POS_W-1], a} + {b[POS_W-1], b};
    c = s[POS_W-1:17];
    if (s[POS_W]) begin
      return '0;
    end
    if (c >= (POS_W-17)'(dim)) begin
      return dim - 1'b1;
    end
    return c[DIM_W-1:0];
  endfunction

  // Configuration registers
  logic [DIM_W-1:0]  width_q, height_q;
  logic [KLEN_W-1:0] klen_q;
  logic [MINC_W-1:0] minc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(256);
      height_q <= DIM_W'(256);
      klen_q   <= KLEN_W'(10);
      minc_q   <= MINC_W'(1638);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_WIDTH:  width_q  <= cfg_wdata_i[DIM_W-1:0];
        CFG_HEIGHT: height_q <= cfg_wdata_i[DIM_W-1:0];
        CFG_KERNEL: klen_q   <= cfg_wdata_i[KLEN_W-1:0];
        CFG_MINC:   minc_q   <= cfg_wdata_i[MINC_W-1:0];
        default:    ;
      endcase
    end
  end

  // Saturated sizes
  logic [DIM_W-1:0]  w_eff, h_eff;
  logic [KLEN_W-1:0] k_eff;
  logic [STEP_W-1:0] kq;
  logic [CNT_W-1:0]  n_lim;

  always_comb begin
    w_eff = width_q;
    if (width_q == '0) begin
      w_eff = DIM_W'(1);
    end else if (int'(width_q) > MAX_WIDTH) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end
    h_eff = height_q;
    if (height_q == '0) begin
      h_eff = DIM_W'(1);
    end else if (int'(height_q) > MAX_HEIGHT) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end
    k_eff = klen_q;
    if (klen_q == '0) begin
      k_eff = KLEN_W'(1);
    end else if (klen_q > KERNEL_MAX) begin
      k_eff = KERNEL_MAX;
    end
    kq    = {k_eff, 16'b0};
    n_lim = CNT_W'({k_eff, 1'b0}) + CNT_W'(k_eff);
  end

  // Sequencer and datapath registers
  state_e state_q, state_d;
  logic [7:0]               px_q, px_d, py_q, py_d;
  logic                     back_q, back_d;
  logic signed [POS_W-1:0]  posx_q, posx_d, posy_q, posy_d;
  logic signed [POS_W-1:0]  nx_q, nx_d, ny_q, ny_d;
  logic [STEP_W-1:0]        cur_q, cur_d, step_q, step_d;
  logic [CNT_W-1:0]         n_q, n_d;
  logic [SUM_W-1:0]         s_q, s_d;
  logic [WGT_W-1:0]         wa_q, wa_d, wnew_q, wnew_d;
  logic [TOTS_W-1:0]        tots_q, tots_d;
  logic [TOTW_W-1:0]        totw_q, totw_d;
  logic                     negx_q, negx_d, negy_q, negy_d;
  logic [MAG_W-1:0]         magx_q, magx_d, magy_q, magy_d;
  logic [SEG_W-1:0]         seg_q, seg_d;
  logic [7:0]               res_q, res_d;
  logic [ADDR_W-1:0]        clr_q, clr_d;

  // Memory, divider and multiplier hookups
  logic              vec_we, vec_re, tex_we, tex_re;
  logic [ADDR_W-1:0] vec_waddr, vec_raddr, tex_raddr, ld_addr;
  logic [31:0]       vec_wdata, vec_rdata;
  logic [7:0]        tex_rdata;
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;

  // Combinational temporaries
  logic              in_acc, ld_ok;
  logic signed [15:0] fx, fy;
  logic [16:0]       gap;
  logic [CUR_W-1:0]  cur_sum;
  logic [PROD_W-16:0] mv;
  logic signed [POS_W-1:0] mv_s;
  logic [DIM_W-1:0]  scx, scy;
  logic              leave;

  assign in_acc = in_valid_i && in_ready_o;
  assign ld_ok  = (int'(pixel_x_i) < MAX_WIDTH) && (int'(pixel_y_i) < MAX_HEIGHT);
  assign ld_addr = cell_addr(DIM_W'(pixel_x_i), DIM_W'(pixel_y_i));
  assign fx = vec_rdata[15:0];
  assign fy = vec_rdata[31:16];
  assign mv = prod[PROD_W-1:15];
  assign mv_s = signed'(POS_W'(mv));

  // Next state and datapath control
  always_comb begin
    state_d = state_q;
    px_d = px_q;     py_d = py_q;     back_d = back_q;
    posx_d = posx_q; posy_d = posy_q; nx_d = nx_q; ny_d = ny_q;
    cur_d = cur_q;   step_d = step_q; n_d = n_q;
    s_d = s_q;       wa_d = wa_q;     wnew_d = wnew_q;
    tots_d = tots_q; totw_d = totw_q;
    negx_d = negx_q; negy_d = negy_q; magx_d = magx_q; magy_d = magy_q;
    seg_d = seg_q;   res_d = res_q;   clr_d = clr_q;

    vec_we = 1'b0; vec_waddr = ld_addr; vec_wdata = {vector_y_i, vector_x_i};
    vec_re = 1'b0; vec_raddr = cell_addr(posx_q[16 +: DIM_W], posy_q[16 +: DIM_W]);
    tex_we = 1'b0; tex_re = 1'b0;
    scx = sample_cell(posx_q, nx_q, w_eff);
    scy = sample_cell(posy_q, ny_q, h_eff);
    tex_raddr = cell_addr(scx, scy);
    div_req = '0;
    mul_a = step_q; mul_b = magx_q;
    gap = '0;
    cur_sum = CUR_W'(cur_q) + CUR_W'(seg_q);
    leave = 1'b0;
    in_ready_o = 1'b0;

    unique case (state_q)
      // Write zero vectors to every entry after reset
      S_CLR: begin
        vec_we    = 1'b1;
        vec_waddr = clr_q;
        vec_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      // Take a load or a query
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_acc) begin
          if (op_e'(op_i) == OP_LOAD) begin
            vec_we = ld_ok;
            tex_we = ld_ok;
          end else begin
            px_d   = pixel_x_i;
            py_d   = pixel_y_i;
            back_d = 1'b1;
            tots_d = '0;
            totw_d = '0;
            res_d  = '0;
            if (DIM_W'(pixel_x_i) < w_eff && DIM_W'(pixel_y_i) < h_eff) begin
              state_d = S_TINIT;
            end else begin
              state_d = S_OUT;
            end
          end
        end
      end
      // Start a trace at the pixel centre
      S_TINIT: begin
        posx_d  = signed'(POS_W'({px_q, 1'b1, 15'b0}));
        posy_d  = signed'(POS_W'({py_q, 1'b1, 15'b0}));
        cur_d   = '0;
        n_d     = '0;
        s_d     = '0;
        wa_d    = '0;
        state_d = S_TCHK;
      end
      // Stop on length or step limit, else fetch the cell's vector
      S_TCHK: begin
        if (cur_q >= kq || n_q >= n_lim) begin
          state_d = S_TEND;
        end else begin
          vec_re  = 1'b1;
          state_d = S_TVEC;
        end
      end
      // Split the vector into direction and magnitude; a zero vector ends the trace
      S_TVEC: begin
        if (fx == '0 && fy == '0) begin
          if (n_q == '0) begin
            wa_d = WGT_W'(1);
          end
          state_d = S_TEND;
        end else begin
          negx_d  = fx[15] ^ back_q;
          negy_d  = fy[15] ^ back_q;
          magx_d  = fx[15] ? MAG_W'(-fx) : MAG_W'(fx);
          magy_d  = fy[15] ? MAG_W'(-fy) : MAG_W'(fy);
          seg_d   = CLIP_LEN;
          state_d = S_DXS;
        end
      end
      // Exit length along x
      S_DXS: begin
        gap = negx_q ? {1'b0, posx_q[15:0]} : 17'h10000 - {1'b0, posx_q[15:0]};
        if (magx_q > MAG_W'(minc_q)) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIVD_W'({gap, 15'b0}) + DIVD_W'(magx_q - 1'b1);
          div_req.divisor  = magx_q;
          state_d = S_DXW;
        end else begin
          state_d = S_DYS;
        end
      end
      S_DXW: begin
        if (div_rsp.done) begin
          if (div_rsp.quotient < seg_q) begin
            seg_d = div_rsp.quotient;
          end
          state_d = S_DYS;
        end
      end
      // Exit length along y
      S_DYS: begin
        gap = negy_q ? {1'b0, posy_q[15:0]} : 17'h10000 - {1'b0, posy_q[15:0]};
        if (magy_q > MAG_W'(minc_q)) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIVD_W'({gap, 15'b0}) + DIVD_W'(magy_q - 1'b1);
          div_req.divisor  = magy_q;
          state_d = S_DYW;
        end else begin
          state_d = S_ADV;
        end
      end
      S_DYW: begin
        if (div_rsp.done) begin
          if (div_rsp.quotient < seg_q) begin
            seg_d = div_rsp.quotient;
          end
          state_d = S_ADV;
        end
      end
      // Advance the travelled length, clamp to the kernel
      S_ADV: begin
        if (cur_sum > CUR_W'(kq)) begin
          cur_d  = kq;
          step_d = kq - cur_q;
        end else begin
          cur_d  = cur_sum[STEP_W-1:0];
          step_d = seg_q[STEP_W-1:0] + OVERSHOOT;
        end
        state_d = S_MX;
      end
      // Movement along x
      S_MX: begin
        mul_a   = step_q;
        mul_b   = magx_q;
        state_d = S_MY;
      end
      // Movement along y; new x position
      S_MY: begin
        mul_a   = step_q;
        mul_b   = magy_q;
        nx_d    = negx_q ? posx_q - mv_s : posx_q + mv_s;
        state_d = S_MW;
      end
      // New y position; weight numerator
      S_MW: begin
        mul_a   = cur_q;
        mul_b   = WMAX;
        ny_d    = negy_q ? posy_q - mv_s : posy_q + mv_s;
        state_d = S_SAMP;
      end
      // Fetch the noise at the midpoint; divide the weight by the kernel
      S_SAMP: begin
        tex_re           = 1'b1;
        div_req.start    = 1'b1;
        div_req.dividend = DIVD_W'(prod >> 16);
        div_req.divisor  = DIVS_W'(k_eff);
        state_d          = S_WWAIT;
      end
      S_WWAIT: begin
        if (div_rsp.done) begin
          wnew_d  = div_rsp.quotient[WGT_W-1:0];
          state_d = S_ACC;
        end
      end
      // Weight the noise by the weight gained
      S_ACC: begin
        mul_a   = MUL_A_W'(tex_rdata);
        mul_b   = MUL_B_W'(wnew_q - wa_q);
        state_d = S_ACC2;
      end
      // Accumulate and move; stop on leaving the image
      S_ACC2: begin
        s_d    = s_q + prod[SUM_W-1:0];
        wa_d   = wnew_q;
        n_d    = n_q + 1'b1;
        posx_d = nx_q;
        posy_d = ny_q;
        leave  = nx_q[POS_W-1] || ny_q[POS_W-1] ||
                 (nx_q >= signed'(POS_W'({w_eff, 16'b0}))) ||
                 (ny_q >= signed'(POS_W'({h_eff, 16'b0})));
        state_d = leave ? S_TEND : S_TCHK;
      end
      // Fold the trace into the totals; forward trace follows backward
      S_TEND: begin
        tots_d = tots_q + TOTS_W'(s_q);
        totw_d = totw_q + TOTW_W'(wa_q);
        if (back_q) begin
          back_d  = 1'b0;
          state_d = S_TINIT;
        end else begin
          state_d = S_FIN;
        end
      end
      // Normalize by the total weight
      S_FIN: begin
        if (totw_q == '0) begin
          res_d   = '0;
          state_d = S_OUT;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = DIVD_W'(tots_q);
          div_req.divisor  = DIVS_W'(totw_q);
          state_d          = S_FINW;
        end
      end
      S_FINW: begin
        if (div_rsp.done) begin
          res_d   = (div_rsp.quotient > DIVD_W'(INTENS_MAX)) ? INTENS_MAX :
                    div_rsp.quotient[7:0];
          state_d = S_OUT;
        end
      end
      // Hold the result until taken
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    px_q <= px_d;     py_q <= py_d;     back_q <= back_d;
    posx_q <= posx_d; posy_q <= posy_d; nx_q <= nx_d; ny_q <= ny_d;
    cur_q <= cur_d;   step_q <= step_d; n_q <= n_d;
    s_q <= s_d;       wa_q <= wa_d;     wnew_q <= wnew_d;
    tots_q <= tots_d; totw_q <= totw_d;
    negx_q <= negx_d; negy_q <= negy_d; magx_q <= magx_d; magy_q <= magy_d;
    seg_q <= seg_d;   res_q <= res_d;
  end

  // Vector store, x in the low half
  lic_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (vec_we),
    .waddr_i (vec_waddr),
    .wdata_i (vec_wdata),
    .re_i    (vec_re),
    .raddr_i (vec_raddr),
    .rdata_o (vec_rdata)
  );

  // Noise store
  lic_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_tex_ram (
    .clk_i   (clk_i),
    .we_i    (tex_we),
    .waddr_i (ld_addr),
    .wdata_i (texel_i),
    .re_i    (tex_re),
    .raddr_i (tex_raddr),
    .rdata_o (tex_rdata)
  );

  lic_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  lic_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign out_valid_o = (state_q == S_OUT);
  assign intensity_o = res_q;
  assign out_x_o     = px_q;
  assign out_y_o     = py_q;

  // A request is never taken while a result waits
  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("request taken while a result is pending");

  // The step count never passes three kernel lengths
  a_step_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TCHK) |-> (n_q <= n_lim))
    else $error("step count beyond limit");

  // The clamped length never passes the kernel length
  a_len_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MX) |-> (cur_q <= kq))
    else $error("travelled length beyond kernel");

  // The divider is only started when its result is awaited next
  a_div_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |=> (state_q == S_DXW || state_q == S_DYW ||
                       state_q == S_WWAIT || state_q == S_FINW))
    else $error("divider started out of sequence");

endmodule
